// ----- hdl/d2i_pkg.sv -----
// Package for the double to integer converter: field widths and constants.
// Used by d2i_core, double_to_int_round_nearest and the checker.
package d2i_pkg;
  localparam int unsigned IntWidth  = 32;
  localparam int unsigned FracBits  = 52;
  localparam int unsigned ExpBits   = 11;
  localparam int unsigned MantBits  = FracBits + 1;
  localparam int unsigned ShiftBias = 1075;
  localparam int unsigned ShBits    = 12;
  localparam logic [ExpBits-1:0] ExpAllOnes = '1;

  typedef struct packed {
    logic [IntWidth-1:0] value;
    logic                inexact;
    logic                invalid;
  } result_t;
endpackage

// ----- hdl/d2i_core.sv -----
// Combinational conversion of one double bit pattern to a rounded integer.
// Depends on d2i_pkg.
module d2i_core (
  input  logic [63:0]       bits_i,
  output d2i_pkg::result_t  res_o
);
  localparam int unsigned MW = d2i_pkg::MantBits;
  localparam int unsigned IW = d2i_pkg::IntWidth;
  localparam int unsigned SB = d2i_pkg::ShBits;
  localparam int unsigned AW = MW + 12;

  logic                            neg;
  logic [d2i_pkg::ExpBits-1:0]     ex;
  logic [d2i_pkg::FracBits-1:0]    frac;
  logic [MW-1:0]                   m;
  logic [SB-1:0]                   e;
  logic [SB-1:0]                   sh;
  logic [SB-1:0]                   left;
  logic [MW:0]                     ext;
  logic [MW:0]                     rnd;
  logic [AW-1:0]                   mag;
  logic [AW-1:0]                   top;
  logic                            too_big;
  logic                            inex;
  logic [AW-1:0]                   sat;

  always_comb begin
    neg  = bits_i[63];
    ex   = bits_i[62:52];
    frac = bits_i[51:0];
    m    = (ex == '0) ? {1'b0, frac} : {1'b1, frac};
    e    = (ex == '0) ? SB'(1) : {1'b0, ex};
    sh   = SB'(d2i_pkg::ShiftBias) - e;
    left = e - SB'(d2i_pkg::ShiftBias);
    top  = AW'(1) << (IW - 1);
    ext  = '0;
    rnd  = '0;
    mag  = '0;
    inex = 1'b0;
    too_big = 1'b0;
    if (ex == d2i_pkg::ExpAllOnes) begin
      too_big = 1'b1;
    end else if ($signed(sh) <= 0) begin
      if (left > SB'(11)) too_big = 1'b1;
      else mag = AW'(m) << left[3:0];
    end else if (sh >= SB'(54)) begin
      inex = (m != '0);
    end else begin
      // Keep one guard bit, then add half a unit and drop it.
      ext  = {m, 1'b0} >> sh[5:0];
      rnd  = ext + (MW+1)'(1);
      mag  = AW'(rnd[MW:1]);
      inex = ((m & ((MW'(1) << sh[5:0]) - MW'(1))) != '0);
    end
    if (!too_big && (neg ? (mag > top) : (mag > top - AW'(1)))) too_big = 1'b1;
    sat = too_big ? (neg ? top : top - AW'(1)) : mag;
    res_o.value   = IW'(neg ? (AW'(0) - sat) : sat);
    res_o.inexact = inex;
    res_o.invalid = too_big;
    if (ex == d2i_pkg::ExpAllOnes && frac != '0) begin
      res_o.value   = '0;
      res_o.inexact = 1'b0;
      res_o.invalid = 1'b1;
    end
  end
endmodule

// ----- hdl/double_to_int_round_nearest.sv -----
// Top level: double to 32-bit integer, round to nearest, ties away from zero.
// Depends on d2i_pkg and d2i_core.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   input    | in_valid_i/in_ready_o | double_bits_i
//   output   | out_valid_o/out_ready_i | int_value_o, inexact_o, invalid_o
//
// One word per cycle is accepted while the output is not stalled; a result
// appears in the cycle after its word is taken, from the single result register.
// The input is ready whenever the result register is empty or being drained,
// so stalls on the output propagate back in the same cycle.
// Reset clears only the valid flag; the result payload holds no reset value.
module double_to_int_round_nearest (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [63:0]                         double_bits_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [d2i_pkg::IntWidth-1:0] int_value_o,
  output logic                                inexact_o,
  output logic                                invalid_o
);
  d2i_pkg::result_t res_d, res_q;
  logic             valid_q;

  d2i_core u_core (.bits_i(double_bits_i), .res_o(res_d));

  // A word may enter whenever the result register will be free.
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign int_value_o = $signed(res_q.value);
  assign inexact_o   = res_q.inexact;
  assign invalid_o   = res_q.invalid;
endmodule

// ----- hdl/d2i_checker.sv -----
// Port-level checker for double_to_int_round_nearest, with its bind.
// Depends on d2i_pkg.
module d2i_props (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [d2i_pkg::IntWidth-1:0]    int_value_o,
  input logic                            inexact_o,
  input logic                            invalid_o
);
  // An accepted word yields a result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o) else $error("missing result");
  // The input is never blocked while no result is pending.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("input stalled while empty");
  // A stalled result stays in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(int_value_o))
    else $error("result changed under stall");
  // A NaN result (invalid with value zero) never reports a fraction.
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o && int_value_o == '0 |-> !inexact_o)
    else $error("NaN result flagged inexact");
endmodule

bind double_to_int_round_nearest d2i_props u_d2i_props (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .int_value_o(int_value_o),
  .inexact_o(inexact_o), .invalid_o(invalid_o)
);
